// ----- sv/keyboard_scancode_fifo_top_macros.svh -----
// Assertion macros used by the keyboard scancode FIFO checker.
`ifndef KEYBOARD_SCANCODE_FIFO_TOP_MACROS_SVH
`define KEYBOARD_SCANCODE_FIFO_TOP_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define KBSF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define KBSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/kbsf_pkg.sv -----
// Types and constants shared by the keyboard scancode FIFO modules.
package kbsf_pkg;

  localparam int FUNC_W     = 2;
  localparam int BYTE_W     = 8;
  localparam int CODE_W     = 7;
  localparam int PAGE_W     = 2;
  localparam int CFG_IDX_W  = 3;

  localparam int DEFAULT_FIFO_DEPTH = 64;

  localparam logic [BYTE_W-1:0] EMPTY_BYTE  = 8'hFF;
  localparam int                RELEASE_BIT = 7;

  localparam logic [CODE_W-1:0] CTRL_CODE_RST = 7'd29;
  localparam logic [CODE_W-1:0] ALT_CODE_RST  = 7'd56;
  localparam logic [CODE_W-1:0] F1_CODE_RST   = 7'd59;
  localparam logic [CODE_W-1:0] F2_CODE_RST   = 7'd60;
  localparam logic [CODE_W-1:0] F3_CODE_RST   = 7'd61;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SCAN  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CTRL = 3'd0,
    CFG_ALT  = 3'd1,
    CFG_F1   = 3'd2,
    CFG_F2   = 3'd3,
    CFG_F3   = 3'd4
  } cfg_idx_t;

  typedef enum logic [PAGE_W-1:0] {
    PAGE_NONE = 2'd0,
    PAGE_1    = 2'd1,
    PAGE_2    = 2'd2,
    PAGE_3    = 2'd3
  } page_t;

  // Requests from the top level to the FIFO for one accepted item.
  typedef struct packed {
    logic push;
    logic read;
    logic clear;
  } fifo_req_t;

  // What the FIFO did with that item.
  typedef struct packed {
    logic popped;
    logic dropped;
  } fifo_stat_t;

  // Modifier state and page request after one item.
  typedef struct packed {
    page_t page;
    logic  ctrl_down;
    logic  alt_down;
  } keys_t;

endpackage

// ----- sv/kbsf_keys.sv -----
// Key code registers, Ctrl and Alt flags and the video page decode.
module kbsf_keys (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [kbsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kbsf_pkg::CODE_W-1:0]    cfg_data,
  input  logic                          scan_we,
  input  logic [kbsf_pkg::BYTE_W-1:0]    scan_byte,
  output kbsf_pkg::keys_t               keys
);
  import kbsf_pkg::*;

  logic [CODE_W-1:0] ctrl_code;
  logic [CODE_W-1:0] alt_code;
  logic [CODE_W-1:0] f1_code;
  logic [CODE_W-1:0] f2_code;
  logic [CODE_W-1:0] f3_code;
  logic              ctrl_held;
  logic              alt_held;
  logic              ctrl_held_next;
  logic              alt_held_next;
  logic [CODE_W-1:0] code;
  logic              is_release;

  assign code       = scan_byte[CODE_W-1:0];
  assign is_release = scan_byte[RELEASE_BIT];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_code <= CTRL_CODE_RST;
      alt_code  <= ALT_CODE_RST;
      f1_code   <= F1_CODE_RST;
      f2_code   <= F2_CODE_RST;
      f3_code   <= F3_CODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CTRL: ctrl_code <= cfg_data;
        CFG_ALT:  alt_code  <= cfg_data;
        CFG_F1:   f1_code   <= cfg_data;
        CFG_F2:   f2_code   <= cfg_data;
        CFG_F3:   f3_code   <= cfg_data;
        default: ;
      endcase
    end
  end

  // A make code sets a flag on a match, a release clears it.
  always_comb begin
    ctrl_held_next = ctrl_held;
    alt_held_next  = alt_held;
    if (scan_we) begin
      if (code == ctrl_code) ctrl_held_next = !is_release;
      if (code == alt_code)  alt_held_next  = !is_release;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_held <= 1'b0;
      alt_held  <= 1'b0;
    end else begin
      ctrl_held <= ctrl_held_next;
      alt_held  <= alt_held_next;
    end
  end

  // The highest matching page wins, and Ctrl counts as held once set.
  always_comb begin
    keys.page      = PAGE_NONE;
    keys.ctrl_down = ctrl_held_next;
    keys.alt_down  = alt_held_next;
    if (!is_release && ctrl_held_next) begin
      if (code == f3_code) begin
        keys.page = PAGE_3;
      end else if (code == f2_code) begin
        keys.page = PAGE_2;
      end else if (code == f1_code) begin
        keys.page = PAGE_1;
      end
    end
  end

endmodule

// ----- sv/kbsf_fifo.sv -----
// Ring FIFO of scan codes with pointers, fill count and registered read data.
module kbsf_fifo #(
  parameter int FIFO_DEPTH = kbsf_pkg::DEFAULT_FIFO_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  kbsf_pkg::fifo_req_t        req,
  input  logic [kbsf_pkg::CODE_W-1:0] code,
  output kbsf_pkg::fifo_stat_t       stat,
  output logic [kbsf_pkg::BYTE_W-1:0] rd_data
);
  import kbsf_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(FIFO_DEPTH);

  logic [BYTE_W-1:0] mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  write_ptr;
  logic [PTR_W-1:0]  read_ptr;
  logic [CNT_W-1:0]  fill_count;
  logic [PTR_W-1:0]  write_ptr_next;
  logic [PTR_W-1:0]  read_ptr_next;
  logic [CNT_W-1:0]  fill_count_next;
  logic              full;
  logic              empty;
  logic              do_write;

  assign full         = (fill_count == FULL_CNT);
  assign empty        = (fill_count == '0);
  assign do_write     = req.push && !full;
  assign stat.dropped = req.push && full;
  assign stat.popped  = req.read && !empty;

  always_comb begin
    write_ptr_next  = write_ptr;
    read_ptr_next   = read_ptr;
    fill_count_next = fill_count;
    if (req.clear) begin
      write_ptr_next  = '0;
      read_ptr_next   = '0;
      fill_count_next = '0;
    end else if (do_write) begin
      write_ptr_next  = (write_ptr == LAST_SLOT) ? '0 : write_ptr + 1'b1;
      fill_count_next = fill_count + 1'b1;
    end else if (stat.popped) begin
      read_ptr_next   = (read_ptr == LAST_SLOT) ? '0 : read_ptr + 1'b1;
      fill_count_next = fill_count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr  <= '0;
      read_ptr   <= '0;
      fill_count <= '0;
    end else begin
      write_ptr  <= write_ptr_next;
      read_ptr   <= read_ptr_next;
      fill_count <= fill_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[write_ptr] <= {1'b0, code};
    end
  end

  // Read data changes only with a read item, so it holds while the result waits.
  always_ff @(posedge clk) begin
    if (req.read) begin
      rd_data <= mem[read_ptr];
    end
  end

endmodule

// ----- sv/keyboard_scancode_fifo_top.sv -----
// A result item is shown in the cycle after its input item is accepted.
// Throughput: one item per cycle; a waiting result blocks input only when it is stalled.
// The FIFO memory holds 64 entries by default and is read and written through one port each.
// Reset (rst, synchronous, active high) empties the FIFO, clears both flags and the
// result valid flag, and loads the default key codes; no memory clearing pass is needed.
module keyboard_scancode_fifo_top #(
  parameter int FIFO_DEPTH = kbsf_pkg::DEFAULT_FIFO_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [kbsf_pkg::FUNC_W-1:0]     func,
  input  logic [kbsf_pkg::BYTE_W-1:0]     scan_byte,
  input  logic                            page_matches,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [kbsf_pkg::BYTE_W-1:0]     read_byte,
  output logic [kbsf_pkg::PAGE_W-1:0]     page_request,
  output logic                            dropped,
  output logic                            ctrl_down,
  output logic                            alt_down,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kbsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kbsf_pkg::CODE_W-1:0]     cfg_data
);
  import kbsf_pkg::*;

  logic       accept;
  logic       scan_we;
  fifo_req_t  req;
  fifo_stat_t stat;
  keys_t      keys;
  logic [BYTE_W-1:0] rd_data;

  // Result register contents. The popped byte itself sits in the FIFO's read register.
  logic       res_popped;
  page_t      res_page;
  logic       res_dropped;
  logic       res_ctrl;
  logic       res_alt;

  // Configuration writes are always taken; the user must keep the block idle whenever they arrive (no check).
  assign cfg_ready = 1'b1;

  // The result register frees up when it is empty or is being taken this cycle.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Only an accepted scan item may change the modifier flags; accepted scans, reads and clears may change the FIFO.
  assign scan_we   = accept && (func == FUNC_SCAN);
  assign req.push  = scan_we && !scan_byte[RELEASE_BIT];
  assign req.read  = accept && (func == FUNC_READ) && page_matches;
  assign req.clear = accept && (func == FUNC_CLEAR);

  kbsf_keys u_keys (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .scan_we   (scan_we),
    .scan_byte (scan_byte),
    .keys      (keys)
  );

  kbsf_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .code    (scan_byte[CODE_W-1:0]),
    .stat    (stat),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Page requests only come from scan items; other functions report no page.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_popped  <= stat.popped;
      res_page    <= scan_we ? keys.page : PAGE_NONE;
      res_dropped <= stat.dropped;
      res_ctrl    <= keys.ctrl_down;
      res_alt     <= keys.alt_down;
    end
  end

  // A read that popped nothing, and every non-read item, reports the empty byte.
  assign read_byte    = res_popped ? rd_data : EMPTY_BYTE;
  assign page_request = res_page;
  assign dropped      = res_dropped;
  assign ctrl_down    = res_ctrl;
  assign alt_down     = res_alt;

endmodule

// ----- sv/kbsf_checker.sv -----
// Port-level checks for the keyboard scancode FIFO and their binding.
`include "keyboard_scancode_fifo_top_macros.svh"

module kbsf_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [kbsf_pkg::BYTE_W-1:0]    read_byte,
  input logic [kbsf_pkg::PAGE_W-1:0]    page_request,
  input logic                           dropped,
  input logic                           ctrl_down
);
  import kbsf_pkg::*;

  // A stalled result keeps its popped byte.
  `KBSF_ASSERT_NEXT(a_result_holds, out_valid && out_stall, out_valid && $stable(read_byte), "stalled result changed")

  // Every accepted item shows its result in the next cycle.
  `KBSF_ASSERT_NEXT(a_one_cycle, in_valid && !in_stall, out_valid, "accepted item gave no result")

  // A page request comes only from a scan item with Ctrl held.
  `KBSF_ASSERT_NOW(a_page_ctrl, out_valid && page_request != PAGE_NONE, ctrl_down && read_byte == EMPTY_BYTE, "page request without Ctrl or with read data")

  // A dropped code comes from a scan item, which never carries read data.
  `KBSF_ASSERT_NOW(a_drop_no_read, out_valid && dropped, read_byte == EMPTY_BYTE, "dropped flag on a read")

endmodule

bind keyboard_scancode_fifo_top kbsf_checker u_kbsf_checker (.*);

// ----- tb/sv/tb_keyboard_scancode_fifo_top.sv -----
// Self-checking testbench for the keyboard scancode FIFO top level.
`timescale 1ns / 100ps

module tb_keyboard_scancode_fifo_top;
  import kbsf_pkg::*;

  localparam int FIFO_DEPTH     = DEFAULT_FIFO_DEPTH;
  localparam int NUM_PHASES     = 10;
  localparam int ITEMS_PER_PHASE = 150;
  // Cycles in a row with no handshake on any channel before the run is called hung.
  // In a correct run, quiet stretches come only from a drawn input gap, a drawn output
  // stall and the result register.
  localparam int QUIET_LIMIT    = 2000;
  localparam int NUM_DIR_ROWS   = 23;
  localparam int MAX_REPORTS    = 100;

  // One result item as the block shows it.
  typedef struct packed {
    logic [BYTE_W-1:0] byte_out;
    page_t             page;
    logic              drop;
    logic              ctrl;
    logic              alt;
  } scan_result_t;

  // One row of the directed table. When typed is set, want holds the result that can
  // be read straight off the behavior; otherwise the predictor supplies it.
  typedef struct packed {
    func_t             f;
    logic [BYTE_W-1:0] sb;
    logic              pm;
    logic              typed;
    scan_result_t      want;
  } dir_row_t;

  localparam scan_result_t NO_TYPED = '{8'h00, PAGE_NONE, 1'b0, 1'b0, 1'b0};

  // The directed part runs with the reset key codes: Ctrl 0x1D, Alt 0x38 and
  // F1 to F3 at 0x3B to 0x3D.
  localparam dir_row_t DIR_ROWS [NUM_DIR_ROWS] = '{
    // Read of the empty buffer right after reset, then an unused function code.
    '{FUNC_READ,  8'h00, 1'b1, 1'b1, '{EMPTY_BYTE, PAGE_NONE, 1'b0, 1'b0, 1'b0}},
    '{FUNC_NONE,  8'h00, 1'b1, 1'b1, '{EMPTY_BYTE, PAGE_NONE, 1'b0, 1'b0, 1'b0}},
    // Smallest and largest make codes are queued.
    '{FUNC_SCAN,  8'h00, 1'b1, 1'b1, '{EMPTY_BYTE, PAGE_NONE, 1'b0, 1'b0, 1'b0}},
    '{FUNC_SCAN,  8'h7F, 1'b0, 1'b1, '{EMPTY_BYTE, PAGE_NONE, 1'b0, 1'b0, 1'b0}},
    // Smallest and largest release bytes are not queued.
    '{FUNC_SCAN,  8'h80, 1'b1, 1'b1, '{EMPTY_BYTE, PAGE_NONE, 1'b0, 1'b0, 1'b0}},
    '{FUNC_SCAN,  8'hFF, 1'b1, 1'b1, '{EMPTY_BYTE, PAGE_NONE, 1'b0, 1'b0, 1'b0}},
    // A read from the wrong page pops nothing, the next read gets the oldest byte.
    '{FUNC_READ,  8'h00, 1'b0, 1'b1, '{EMPTY_BYTE, PAGE_NONE, 1'b0, 1'b0, 1'b0}},
    '{FUNC_READ,  8'hFF, 1'b1, 1'b1, '{8'h00,      PAGE_NONE, 1'b0, 1'b0, 1'b0}},
    // Ctrl down, then the three function keys ask for their pages.
    '{FUNC_SCAN,  8'h1D, 1'b1, 1'b1, '{EMPTY_BYTE, PAGE_NONE, 1'b0, 1'b1, 1'b0}},
    '{FUNC_SCAN,  8'h3B, 1'b1, 1'b1, '{EMPTY_BYTE, PAGE_1,    1'b0, 1'b1, 1'b0}},
    '{FUNC_SCAN,  8'h3C, 1'b0, 1'b1, '{EMPTY_BYTE, PAGE_2,    1'b0, 1'b1, 1'b0}},
    '{FUNC_SCAN,  8'h3D, 1'b1, 1'b1, '{EMPTY_BYTE, PAGE_3,    1'b0, 1'b1, 1'b0}},
    // Alt down, an unused code keeps both flags, Alt up, then a read gets the oldest byte.
    '{FUNC_SCAN,  8'h38, 1'b1, 1'b1, '{EMPTY_BYTE, PAGE_NONE, 1'b0, 1'b1, 1'b1}},
    '{FUNC_NONE,  8'hFF, 1'b0, 1'b1, '{EMPTY_BYTE, PAGE_NONE, 1'b0, 1'b1, 1'b1}},
    '{FUNC_SCAN,  8'hB8, 1'b1, 1'b1, '{EMPTY_BYTE, PAGE_NONE, 1'b0, 1'b1, 1'b0}},
    '{FUNC_READ,  8'h00, 1'b1, 1'b1, '{8'h7F,      PAGE_NONE, 1'b0, 1'b1, 1'b0}},
    // Ctrl up, then F1 without Ctrl and a release of some other key.
    '{FUNC_SCAN,  8'h9D, 1'b1, 1'b1, '{EMPTY_BYTE, PAGE_NONE, 1'b0, 1'b0, 1'b0}},
    '{FUNC_SCAN,  8'h3B, 1'b1, 1'b0, NO_TYPED},
    '{FUNC_SCAN,  8'hC5, 1'b0, 1'b0, NO_TYPED},
    // A clear keeps Ctrl held and leaves the buffer empty.
    '{FUNC_SCAN,  8'h1D, 1'b1, 1'b1, '{EMPTY_BYTE, PAGE_NONE, 1'b0, 1'b1, 1'b0}},
    '{FUNC_CLEAR, 8'h00, 1'b0, 1'b1, '{EMPTY_BYTE, PAGE_NONE, 1'b0, 1'b1, 1'b0}},
    '{FUNC_READ,  8'h00, 1'b1, 1'b1, '{EMPTY_BYTE, PAGE_NONE, 1'b0, 1'b1, 1'b0}},
    '{FUNC_SCAN,  8'h9D, 1'b1, 1'b1, '{EMPTY_BYTE, PAGE_NONE, 1'b0, 1'b0, 1'b0}}
  };

  // Clock, reset and the ports of the block. Every input starts at a known value.
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  func_t             in_func = FUNC_SCAN;
  logic [BYTE_W-1:0] in_scan_byte = '0;
  logic              in_page_matches = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] read_byte;
  logic [PAGE_W-1:0] page_request;
  logic              dropped;
  logic              ctrl_down;
  logic              alt_down;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CODE_W-1:0] cfg_data = '0;

  // Side band that travels with each input item: a typed expectation from the table.
  logic              item_typed = 1'b0;
  scan_result_t      item_want = NO_TYPED;

  keyboard_scancode_fifo_top #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (in_func),
    .scan_byte   (in_scan_byte),
    .page_matches(in_page_matches),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_byte   (read_byte),
    .page_request(page_request),
    .dropped     (dropped),
    .ctrl_down   (ctrl_down),
    .alt_down    (alt_down),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the block: key codes, the ring buffer and the modifier flags.
  logic [CODE_W-1:0] ctrl_key, alt_key, f1_key, f2_key, f3_key;
  logic [BYTE_W-1:0] ring_mem [FIFO_DEPTH];
  int                wr_slot, rd_slot, fill_level;
  logic              ctrl_on, alt_on;

  // Results still owed by the block, oldest first.
  scan_result_t      owed_results [$];

  // Bookkeeping for the end of the run.
  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int pops_seen = 0;
  int drops_seen = 0;
  int pages_seen = 0;
  int reg_writes = 0;
  int quiet_cycles = 0;
  int hold_left = 0;

  // When set, neither side idles: back to back items and no output stalls.
  logic no_idle = 1'b0;

  function automatic int draw_wait();
    if (no_idle) begin
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  // Works out the result of one accepted item and advances the shadow state.
  function automatic scan_result_t predict_access(func_t f, logic [BYTE_W-1:0] sb,
                                                  logic pm);
    scan_result_t r;
    logic [CODE_W-1:0] code;
    r.byte_out = EMPTY_BYTE;
    r.page = PAGE_NONE;
    r.drop = 1'b0;
    code = sb[CODE_W-1:0];
    case (f)
      FUNC_SCAN: begin
        if (sb[RELEASE_BIT]) begin
          if (code == alt_key) alt_on = 1'b0;
          if (code == ctrl_key) ctrl_on = 1'b0;
        end else begin
          // Flags first, so a Ctrl key that doubles as an F key asks for its page.
          if (code == alt_key) alt_on = 1'b1;
          if (code == ctrl_key) ctrl_on = 1'b1;
          // Checked in page order so that the highest matching page wins.
          if (ctrl_on) begin
            if (code == f1_key) r.page = PAGE_1;
            if (code == f2_key) r.page = PAGE_2;
            if (code == f3_key) r.page = PAGE_3;
          end
          if (fill_level >= FIFO_DEPTH) begin
            r.drop = 1'b1;
          end else begin
            ring_mem[wr_slot] = {1'b0, code};
            wr_slot = (wr_slot + 1 >= FIFO_DEPTH) ? 0 : wr_slot + 1;
            fill_level++;
          end
        end
      end
      FUNC_READ: begin
        if (pm && fill_level != 0) begin
          r.byte_out = ring_mem[rd_slot];
          rd_slot = (rd_slot + 1 >= FIFO_DEPTH) ? 0 : rd_slot + 1;
          fill_level--;
        end
      end
      FUNC_CLEAR: begin
        wr_slot = 0;
        rd_slot = 0;
        fill_level = 0;
      end
      default: begin
      end
    endcase
    r.ctrl = ctrl_on;
    r.alt = alt_on;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatches < MAX_REPORTS) begin
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  // Monitor: checks each accepted result, predicts each accepted input item, follows
  // register writes, drives the output stall and counts cycles with no handshake.
  // All of this sits in one block so the order of queue updates within an edge is fixed.
  always @(posedge clk) begin : monitor
    scan_result_t got;
    scan_result_t want;
    scan_result_t pred;
    logic active;
    int wait_cycles;
    active = 1'b0;
    if (rst) begin
      ctrl_key = CTRL_CODE_RST;
      alt_key = ALT_CODE_RST;
      f1_key = F1_CODE_RST;
      f2_key = F2_CODE_RST;
      f3_key = F3_CODE_RST;
      wr_slot = 0;
      rd_slot = 0;
      fill_level = 0;
      ctrl_on = 1'b0;
      alt_on = 1'b0;
      out_stall <= 1'b0;
      hold_left <= 0;
      quiet_cycles <= 0;
    end else begin
      if (out_valid === 1'b1 && !out_stall) begin
        active = 1'b1;
        got = '{read_byte, page_t'(page_request), dropped, ctrl_down, alt_down};
        if (owed_results.size() == 0) begin
          report_mismatch("result item with nothing expected", int'(got), 0);
        end else begin
          want = owed_results.pop_front();
          results_seen++;
          if (want.byte_out != EMPTY_BYTE) pops_seen++;
          if (want.drop) drops_seen++;
          if (want.page != PAGE_NONE) pages_seen++;
          if (got.byte_out !== want.byte_out) begin
            report_mismatch("read_byte", int'(got.byte_out), int'(want.byte_out));
          end
          if (got.page !== want.page) begin
            report_mismatch("page_request", int'(got.page), int'(want.page));
          end
          if (got.drop !== want.drop) begin
            report_mismatch("dropped", int'(got.drop), int'(want.drop));
          end
          if (got.ctrl !== want.ctrl) begin
            report_mismatch("ctrl_down", int'(got.ctrl), int'(want.ctrl));
          end
          if (got.alt !== want.alt) begin
            report_mismatch("alt_down", int'(got.alt), int'(want.alt));
          end
        end
        // Draw how long the receiver holds off before it takes the next result.
        wait_cycles = draw_wait();
        out_stall <= (wait_cycles != 0);
        hold_left <= wait_cycles;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= (hold_left > 1);
      end

      if (in_valid && in_stall === 1'b0) begin
        active = 1'b1;
        pred = predict_access(in_func, in_scan_byte, in_page_matches);
        owed_results.push_back(item_typed ? item_want : pred);
        items_sent++;
      end

      if (cfg_valid && cfg_ready === 1'b1) begin
        active = 1'b1;
        reg_writes++;
        case (cfg_index)
          CFG_CTRL: ctrl_key = cfg_data;
          CFG_ALT:  alt_key = cfg_data;
          CFG_F1:   f1_key = cfg_data;
          CFG_F2:   f2_key = cfg_data;
          CFG_F3:   f3_key = cfg_data;
          default: begin
          end
        endcase
      end

      quiet_cycles <= active ? 0 : quiet_cycles + 1;
    end
  end

  // Presents one input item, waits for the edge where it is accepted, then
  // idles for a drawn number of cycles. With no idling, valid stays high so the
  // caller can put the next item on the same edge.
  task automatic send_item(func_t f, logic [BYTE_W-1:0] sb, logic pm, logic typed,
                           scan_result_t want);
    int gap;
    in_valid <= 1'b1;
    in_func <= f;
    in_scan_byte <= sb;
    in_page_matches <= pm;
    item_typed <= typed;
    item_want <= want;
    do @(posedge clk); while (in_stall !== 1'b0);
    gap = draw_wait();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Presents one register write and returns at the edge where it is taken.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CODE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  // Main sequence: reset, the directed table, then phases of random items, each
  // under its own set of key codes.
  initial begin : stimulus
    logic [CODE_W-1:0] codes [5];
    logic [CODE_W-1:0] shared;
    logic [CODE_W-1:0] code;
    logic fill_heavy;
    logic rel;
    int r;
    func_t f;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, under the reset key codes.
    for (int i = 0; i < NUM_DIR_ROWS; i++) begin
      send_item(DIR_ROWS[i].f, DIR_ROWS[i].sb, DIR_ROWS[i].pm, DIR_ROWS[i].typed,
                DIR_ROWS[i].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      // Key codes change only while the block has nothing in flight; every item
      // gives a result, so an empty queue of owed results means idle. The first
      // edge is waited for so that the last accepted item is already queued.
      in_valid <= 1'b0;
      item_typed <= 1'b0;
      do @(posedge clk); while (owed_results.size() != 0);

      case (p)
        0: codes = '{CTRL_CODE_RST, ALT_CODE_RST, F1_CODE_RST, F2_CODE_RST, F3_CODE_RST};
        // All codes equal and at the low extreme: Ctrl and Alt move together, every
        // F key matches at once and Ctrl itself asks for the highest page.
        1: codes = '{7'h00, 7'h00, 7'h00, 7'h00, 7'h00};
        2: codes = '{7'h7F, 7'h7F, 7'h7F, 7'h7F, 7'h7F};
        3: begin
          shared = CODE_W'($urandom_range(0, 127));
          codes = '{shared, shared, CODE_W'($urandom_range(0, 127)),
                    CODE_W'($urandom_range(0, 127)), CODE_W'($urandom_range(0, 127))};
        end
        // Equal F codes, with Ctrl on that same code.
        4: begin
          shared = CODE_W'($urandom_range(0, 127));
          codes = '{shared, CODE_W'($urandom_range(0, 127)), shared, shared, shared};
        end
        default: begin
          for (int k = 0; k < 5; k++) codes[k] = CODE_W'($urandom_range(0, 127));
        end
      endcase
      for (int k = CFG_CTRL; k <= CFG_F3; k++) begin
        write_reg(cfg_idx_t'(k), codes[k]);
      end
      // Writes to indexes past the last register must change nothing.
      if (p == 2) begin
        for (int k = CFG_F3 + 1; k < (1 << CFG_IDX_W); k++) begin
          write_reg(CFG_IDX_W'(k), CODE_W'($urandom_range(0, 127)));
        end
      end
      cfg_valid <= 1'b0;

      // Some phases run with no idling on either side, some lean toward filling the
      // buffer so that it runs full and drops make codes.
      no_idle = (p % 3 == 2);
      fill_heavy = (p % 3 == 1);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = $urandom_range(0, 99);
        if (fill_heavy) begin
          f = (r < 88) ? FUNC_SCAN : (r < 96) ? FUNC_READ : FUNC_NONE;
        end else begin
          f = (r < 50) ? FUNC_SCAN : (r < 88) ? FUNC_READ : (r < 95) ? FUNC_NONE : FUNC_CLEAR;
        end
        // Half the bytes hit one of the configured keys, the rest are arbitrary.
        if ($urandom_range(0, 1) == 1) begin
          code = codes[$urandom_range(0, 4)];
        end else begin
          code = CODE_W'($urandom_range(0, 127));
        end
        rel = ($urandom_range(0, 99) < (fill_heavy ? 10 : 30));
        send_item(f, {rel, code}, ($urandom_range(0, 9) != 0), 1'b0, NO_TYPED);
      end
    end

    // Drain: wait for every owed result, then keep running for anything stray.
    in_valid <= 1'b0;
    no_idle = 1'b0;
    do @(posedge clk); while (owed_results.size() != 0);
    repeat (8) @(posedge clk);

    $display("Sent %0d items over %0d key code settings with %0d register writes.",
             items_sent, NUM_PHASES + 1, reg_writes);
    $display("Checked %0d results: %0d bytes popped, %0d drops, %0d page requests.",
             results_seen, pops_seen, drops_seen, pages_seen);
    if (mismatches == 0) begin
      $display("keyboard_scancode_fifo_top test passed");
    end else begin
      $display("keyboard_scancode_fifo_top test failed");
    end
    $finish;
  end

  // Watchdog: ends a hung run once no channel has moved for too long.
  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Timeout: no handshake for %0d cycles, %0d results still owed.",
             QUIET_LIMIT, owed_results.size());
    $display("keyboard_scancode_fifo_top test failed");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/kbsf_pkg.sv
sv/kbsf_keys.sv
sv/kbsf_fifo.sv
sv/keyboard_scancode_fifo_top.sv
sv/kbsf_checker.sv
tb/sv/tb_keyboard_scancode_fifo_top.sv
